// File: rtl/idiv_pkg.sv
// Package for the 64-bit integer divider: widths, opcode and state types,
// and the control bundle from sequencer to datapath. No dependencies.
package idiv_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int OUT_W      = 64;
   localparam int OP_W       = 2;
   localparam int SUB_W      = DATA_WIDTH + 1;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   typedef enum logic [OP_W-1:0] {
      OP_UQUO = 2'd0,
      OP_UREM = 2'd1,
      OP_SQUO = 2'd2
   } idiv_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_A,
      ST_NEG_B,
      ST_DIVIDE,
      ST_FIX,
      ST_DONE
   } idiv_state_type;

   typedef struct packed {
      logic load;
      logic neg_a;
      logic neg_b;
      logic step;
      logic fix;
   } idiv_ctl_type;

endpackage

// File: rtl/int64_divider_unit.sv
// 64-bit integer divider top: sequencer, datapath and result register.
// A request beat is handled in order: a load, negation of the dividend and then the divisor,
// DATA_WIDTH subtract steps through the shared subtractor, a fixup, and a handoff into the
// result register. A new request beat is taken only once the last result has been handed
// off to the result register, so a stalled result beat also holds off the next request.
// Reset (synchronous) returns the sequencer to idle and drops the result beat.
module int64_divider_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [idiv_pkg::OP_W-1:0]         req_opcode,
   input  logic [idiv_pkg::OUT_W-1:0]        req_dividend,
   input  logic [idiv_pkg::OUT_W-1:0]        req_divisor,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [idiv_pkg::OUT_W-1:0]        rsp_result,
   output logic                              rsp_divide_by_zero
);
   import idiv_pkg::*;

   idiv_ctl_type          ctl;
   logic                  out_free;
   logic                  out_load;
   logic [DATA_WIDTH-1:0] res;
   logic                  dbz;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_result_ff, rsp_result_in;
   logic                  rsp_dbz_ff, rsp_dbz_in;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   idiv_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .out_load  (out_load),
      .ctl       (ctl)
   );

   idiv_datapath u_datapath (
      .clock        (clock),
      .ctl          (ctl),
      .req_opcode   (req_opcode),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .res          (res),
      .dbz          (dbz)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_dbz_in    = rsp_dbz_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = OUT_W'(res);
         rsp_dbz_in    = dbz;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
      rsp_dbz_ff    <= rsp_dbz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("divider took a new beat while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0))
      else $error("divide by zero with nonzero result");

   a_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      out_load |-> req_stall)
      else $error("result loaded while sequencer idle");

endmodule

// File: rtl/idiv_datapath.sv
// Divider datapath: operand, remainder and quotient registers around one
// shared subtractor. Depends on idiv_pkg; steered by idiv_seq.
module idiv_datapath (
   input  logic                                clock,
   input  idiv_pkg::idiv_ctl_type              ctl,
   input  logic [idiv_pkg::OP_W-1:0]           req_opcode,
   input  logic [idiv_pkg::OUT_W-1:0]          req_dividend,
   input  logic [idiv_pkg::OUT_W-1:0]          req_divisor,
   output logic [idiv_pkg::DATA_WIDTH-1:0]     res,
   output logic                                dbz
);
   import idiv_pkg::*;

   idiv_op_type           op_ff, op_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  dbz_ff, dbz_in;

   logic [SUB_W-1:0]      sub_x;
   logic [SUB_W-1:0]      sub_y;
   logic [SUB_W:0]        diff;
   logic                  borrow;
   logic                  signed_op;

   // shared subtractor
   always_comb begin
      sub_x = '0;
      sub_y = '0;
      if (ctl.neg_a || ctl.fix) begin
         sub_y = {1'b0, num_ff};
      end else if (ctl.neg_b) begin
         sub_y = {1'b0, den_ff};
      end else if (ctl.step) begin
         sub_x = {rem_ff, num_ff[DATA_WIDTH-1]};
         sub_y = {1'b0, den_ff};
      end
   end

   assign diff      = {1'b0, sub_x} - {1'b0, sub_y};
   assign borrow    = diff[SUB_W];
   assign signed_op = (op_ff == OP_SQUO);

   always_comb begin
      op_in  = op_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      dbz_in = dbz_ff;
      if (ctl.load) begin
         op_in  = idiv_op_type'(req_opcode);
         num_in = req_dividend[DATA_WIDTH-1:0];
         den_in = req_divisor[DATA_WIDTH-1:0];
         rem_in = '0;
         neg_in = 1'b0;
      end
      if (ctl.neg_a && signed_op && num_ff[DATA_WIDTH-1]) begin
         num_in = diff[DATA_WIDTH-1:0];
         neg_in = ~neg_ff;
      end
      if (ctl.neg_b && signed_op && den_ff[DATA_WIDTH-1]) begin
         den_in = diff[DATA_WIDTH-1:0];
         neg_in = ~neg_ff;
      end
      if (ctl.step) begin
         if (borrow) begin
            rem_in = {rem_ff[DATA_WIDTH-2:0], num_ff[DATA_WIDTH-1]};
         end else begin
            rem_in = diff[DATA_WIDTH-1:0];
         end
         num_in = {num_ff[DATA_WIDTH-2:0], ~borrow};
      end
      if (ctl.fix) begin
         dbz_in = 1'b0;
         case (op_ff)
            OP_UQUO: res_in = num_ff;
            OP_UREM: res_in = rem_ff;
            OP_SQUO: res_in = neg_ff ? diff[DATA_WIDTH-1:0] : num_ff;
            default: res_in = '0;
         endcase
         if ((op_ff inside {OP_UQUO, OP_UREM, OP_SQUO}) && (den_ff == '0)) begin
            res_in = '0;
            dbz_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      dbz_ff <= dbz_in;
   end

   assign res = res_ff;
   assign dbz = dbz_ff;

endmodule

// File: rtl/idiv_seq.sv
// Divider sequencer: state machine and step counter that drive the shared
// subtractor one step per cycle. Depends on idiv_pkg.
module idiv_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   output logic                   req_stall,
   output logic                   out_load,
   output idiv_pkg::idiv_ctl_type ctl
);
   import idiv_pkg::*;

   idiv_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl       = '0;
      out_load  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_NEG_A;
            end
         end
         ST_NEG_A: begin
            ctl.neg_a = 1'b1;
            state_in  = ST_NEG_B;
         end
         ST_NEG_B: begin
            ctl.neg_b = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            ctl.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
